// ===== sv/mkrf_pkg.sv =====
// Package for the multi-keyword record filter: sizes, codes and shared types.
package mkrf_pkg;

  localparam int NUM_KEYS    = 8;
  localparam int MAX_KEY_LEN = 32;

  localparam int KEY_IDX_W = 3;
  localparam int KEY_POS_W = 5;
  localparam int KEY_LEN_W = 6;
  localparam int COUNT_W   = 4;
  localparam int BYTE_W    = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                 cmd;
    logic [KEY_IDX_W-1:0] key_index;
    logic [KEY_POS_W-1:0] key_pos;
    byte_t                key_byte;
    logic [KEY_LEN_W-1:0] key_length;
    byte_t                data_byte;
    logic                 last_byte;
  } in_beat_t;

  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] index;
    logic [KEY_POS_W-1:0] pos;
    byte_t                value;
    logic [KEY_LEN_W-1:0] length;
  } key_wr_t;

  typedef struct packed {
    logic  en;
    logic  last;
    byte_t data;
  } rec_beat_t;

  typedef byte_t [NUM_KEYS-1:0][MAX_KEY_LEN-1:0] key_tbl_t;
  typedef logic [NUM_KEYS-1:0][KEY_LEN_W-1:0]    key_lens_t;
  typedef byte_t [MAX_KEY_LEN-1:0]               window_t;

endpackage

// ===== sv/mkrf_in_if.sv =====
// Input channel of the record filter: load and record beats.
interface mkrf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [mkrf_pkg::KEY_IDX_W-1:0]    key_index;
  logic [mkrf_pkg::KEY_POS_W-1:0]    key_pos;
  logic [mkrf_pkg::BYTE_W-1:0]       key_byte;
  logic [mkrf_pkg::KEY_LEN_W-1:0]    key_length;
  logic [mkrf_pkg::BYTE_W-1:0]       data_byte;
  logic                              last_byte;

  modport source (output valid, cmd, key_index, key_pos, key_byte, key_length, data_byte,
                  last_byte, input ready);
  modport sink (input valid, cmd, key_index, key_pos, key_byte, key_length, data_byte,
                last_byte, output ready);
endinterface

// ===== sv/mkrf_out_if.sv =====
// Output channel of the record filter: one verdict per record.
interface mkrf_out_if;
  logic valid;
  logic ready;
  logic record_matched;

  modport source (output valid, record_matched, input ready);
  modport sink (input valid, record_matched, output ready);
endinterface

// ===== sv/mkrf_key_store.sv =====
// Keyword table and per-slot lengths, written one byte per load beat.
module mkrf_key_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mkrf_pkg::key_wr_t   key_wr_i,
  output mkrf_pkg::key_tbl_t  key_tbl_o,
  output mkrf_pkg::key_lens_t key_lens_o
);

  mkrf_pkg::key_tbl_t  tbl_q;
  mkrf_pkg::key_lens_t lens_q;

  logic slot_ok;
  logic pos_ok;

  assign slot_ok = int'(key_wr_i.index) < mkrf_pkg::NUM_KEYS;
  assign pos_ok  = int'(key_wr_i.pos) < mkrf_pkg::MAX_KEY_LEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lens_q <= '0;
    end else if (key_wr_i.en && slot_ok) begin
      lens_q[key_wr_i.index] <= key_wr_i.length;
    end
  end

  // table contents are undefined until loaded
  always_ff @(posedge clk_i) begin
    if (key_wr_i.en && slot_ok && pos_ok) begin
      tbl_q[key_wr_i.index][key_wr_i.pos] <= key_wr_i.value;
    end
  end

  assign key_tbl_o  = tbl_q;
  assign key_lens_o = lens_q;

endmodule

// ===== sv/mkrf_matcher.sv =====
// Record byte window and parallel compare of all active keywords.
module mkrf_matcher (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mkrf_pkg::COUNT_W-1:0]         cfg_wdata_i,
  input  mkrf_pkg::rec_beat_t                  rec_i,
  input  mkrf_pkg::key_tbl_t                   key_tbl_i,
  input  mkrf_pkg::key_lens_t                  key_lens_i,
  output logic                                 record_matched_o
);

  localparam int MAX_KEY_LEN = mkrf_pkg::MAX_KEY_LEN;
  localparam int NUM_KEYS    = mkrf_pkg::NUM_KEYS;
  localparam int KEY_LEN_W   = mkrf_pkg::KEY_LEN_W;
  localparam int KEY_POS_W   = mkrf_pkg::KEY_POS_W;

  mkrf_pkg::window_t               win_q, win_d;
  logic [KEY_LEN_W-1:0]            seen_q, seen_d;
  logic                            match_q, match_d;
  logic [mkrf_pkg::COUNT_W-1:0]    count_q;

  mkrf_pkg::window_t               win_new;
  logic [KEY_LEN_W-1:0]            seen_new;
  logic [NUM_KEYS-1:0][KEY_LEN_W-1:0] len_c;
  logic [NUM_KEYS-1:0]             hit;
  logic                            match_now;

  always_comb begin
    win_new[0] = rec_i.data;
    for (int j = 1; j < MAX_KEY_LEN; j++) begin
      win_new[j] = win_q[j-1];
    end
    seen_new = (int'(seen_q) >= MAX_KEY_LEN) ? seen_q : seen_q + KEY_LEN_W'(1);
  end

  // keyword k compared so that its last byte sits on the newest window byte
  always_comb begin
    logic [KEY_LEN_W-1:0] tap;
    tap = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      len_c[k] = (int'(key_lens_i[k]) > MAX_KEY_LEN) ? KEY_LEN_W'(MAX_KEY_LEN) : key_lens_i[k];
      hit[k]   = (k < int'(count_q)) && (len_c[k] <= seen_new);
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
        tap = len_c[k] - KEY_LEN_W'(1) - KEY_LEN_W'(i);
        if ((i < int'(len_c[k])) &&
            (key_tbl_i[k][i] != win_new[tap[KEY_POS_W-1:0]])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  assign match_now        = match_q | (|hit);
  assign record_matched_o = match_now;

  always_comb begin
    win_d   = win_q;
    seen_d  = seen_q;
    match_d = match_q;
    if (rec_i.en) begin
      if (rec_i.last) begin
        win_d   = '0;
        seen_d  = '0;
        match_d = 1'b0;
      end else begin
        win_d   = win_new;
        seen_d  = seen_new;
        match_d = match_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      seen_q  <= '0;
      match_q <= 1'b0;
      count_q <= '0;
    end else begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      match_q <= match_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(seen_q) <= MAX_KEY_LEN)
    else $error("byte count past window depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_i.en && rec_i.last |=> seen_q == '0 && !match_q && win_q == '0)
    else $error("record state not cleared after last byte");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q && !(rec_i.en && rec_i.last) |=> match_q)
    else $error("match flag dropped inside a record");

endmodule

// ===== sv/multi_keyword_record_filter.sv =====
// Top level of the multi-keyword record filter.
//
// Input channel in_i carries two kinds of beat. A load beat (cmd low) stores
// one keyword byte at key_index/key_pos and the slot's key_length. A record
// beat (cmd high) feeds data_byte; last_byte ends the record. Keywords in
// slots below keyword_count (cfg_we_i/cfg_wdata_i) are checked on every
// record byte against the bytes seen so far in that record.
// Output channel out_o gives one record_matched beat per record, for the
// beat carrying last_byte.
// A last byte accepted on in_i passes the input register, then the result
// register, before its verdict is valid on out_o. One beat per cycle is
// taken back to back unless a last byte waits on a stalled out_o; the
// compare of all keywords against the 32-byte window is combinational.
// Reset clears lengths, keyword_count, the window and match state; keyword
// bytes are undefined until loaded. While out_o is stalled, a pending
// verdict holds and only a last byte waiting behind it stops in_i.
module multi_keyword_record_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mkrf_pkg::COUNT_W-1:0] cfg_wdata_i,
  mkrf_in_if.sink                      in_i,
  mkrf_out_if.source                   out_o
);

  mkrf_pkg::in_beat_t  s1_q;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic                out_matched_q;

  logic                s1_res;
  logic                out_free;
  logic                s1_adv;
  logic                in_fire;
  logic                res_fire;
  logic                rec_matched;

  mkrf_pkg::key_wr_t   key_wr;
  mkrf_pkg::rec_beat_t rec_beat;
  mkrf_pkg::key_tbl_t  key_tbl;
  mkrf_pkg::key_lens_t key_lens;

  assign s1_res   = s1_valid_q && (s1_q.cmd == mkrf_pkg::CMD_DATA) && s1_q.last_byte;
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && (!s1_res || out_free);
  assign res_fire = s1_res && out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cmd        <= in_i.cmd;
      s1_q.key_index  <= in_i.key_index;
      s1_q.key_pos    <= in_i.key_pos;
      s1_q.key_byte   <= in_i.key_byte;
      s1_q.key_length <= in_i.key_length;
      s1_q.data_byte  <= in_i.data_byte;
      s1_q.last_byte  <= in_i.last_byte;
    end
    if (res_fire) begin
      out_matched_q <= rec_matched;
    end
  end

  always_comb begin
    key_wr.en     = s1_adv && (s1_q.cmd == mkrf_pkg::CMD_LOAD);
    key_wr.index  = s1_q.key_index;
    key_wr.pos    = s1_q.key_pos;
    key_wr.value  = s1_q.key_byte;
    key_wr.length = s1_q.key_length;
    rec_beat.en   = s1_adv && (s1_q.cmd == mkrf_pkg::CMD_DATA);
    rec_beat.last = s1_q.last_byte;
    rec_beat.data = s1_q.data_byte;
  end

  mkrf_key_store u_key_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (key_wr),
    .key_tbl_o  (key_tbl),
    .key_lens_o (key_lens)
  );

  mkrf_matcher u_matcher (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rec_i            (rec_beat),
    .key_tbl_i        (key_tbl),
    .key_lens_i       (key_lens),
    .record_matched_o (rec_matched)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.record_matched = out_matched_q;

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_fire))
    else $error("verdict without a finished record");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("stalled input stage changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !res_fire)
    else $error("pending verdict overwritten");

endmodule

// ===== tb/tb.sv =====
// Testbench for the multi-keyword record filter: directed table, random records, predictor check.
`timescale 1ns / 1ps

module tb;

  localparam int   NUM_KEYS    = mkrf_pkg::NUM_KEYS;
  localparam int   MAX_KEY_LEN = mkrf_pkg::MAX_KEY_LEN;
  localparam int   KEY_IDX_W   = mkrf_pkg::KEY_IDX_W;
  localparam int   KEY_POS_W   = mkrf_pkg::KEY_POS_W;
  localparam int   KEY_LEN_W   = mkrf_pkg::KEY_LEN_W;
  localparam int   COUNT_W     = mkrf_pkg::COUNT_W;
  localparam logic CMD_LOAD    = mkrf_pkg::CMD_LOAD;
  localparam logic CMD_DATA    = mkrf_pkg::CMD_DATA;

  typedef mkrf_pkg::byte_t    byte_t;
  typedef mkrf_pkg::in_beat_t in_beat_t;

  localparam int N_BEATS   = 1150;
  localparam int CYCLE_CAP = 400000;
  localparam int DRAIN     = 4;
  localparam int HOLD_LEN  = 300;

  typedef struct {
    bit               is_cfg;
    bit [COUNT_W-1:0] cfg;
    in_beat_t         beat;
    int               verdict;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  mkrf_in_if  in_ch ();
  mkrf_out_if out_ch ();

  multi_keyword_record_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Keyword store and record window as the filter should hold them.
  byte_t              key_bytes  [NUM_KEYS][MAX_KEY_LEN];
  bit                 key_filled [NUM_KEYS][MAX_KEY_LEN];
  bit [KEY_LEN_W-1:0] key_lens   [NUM_KEYS];
  byte_t              recent     [MAX_KEY_LEN];
  int                 rec_count;
  bit                 rec_hit;
  bit [COUNT_W-1:0]   active_keys;

  bit verdicts_due[$];
  bit want;
  int errors;
  int beats_sent;
  int cycles;
  bit in_calm;
  bit hold_req;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int eff_len(int k);
    return (key_lens[k] > MAX_KEY_LEN) ? MAX_KEY_LEN : int'(key_lens[k]);
  endfunction

  function automatic int live_slots();
    return (active_keys > NUM_KEYS) ? NUM_KEYS : int'(active_keys);
  endfunction

  function automatic bit slot_hit(int k);
    int n;
    n = eff_len(k);
    if (n > rec_count) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (key_bytes[k][i] != recent[n-1-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Returns the verdict for a beat that ends a record, -1 otherwise.
  function automatic int filter_step(in_beat_t b);
    int v;
    if (b.cmd == CMD_LOAD) begin
      key_lens[b.key_index] = b.key_length;
      key_bytes[b.key_index][b.key_pos] = b.key_byte;
      key_filled[b.key_index][b.key_pos] = 1'b1;
      return -1;
    end
    for (int i = MAX_KEY_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b.data_byte;
    if (rec_count < MAX_KEY_LEN) rec_count++;
    for (int k = 0; k < live_slots(); k++) begin
      if (slot_hit(k)) rec_hit = 1'b1;
    end
    if (!b.last_byte) return -1;
    v = rec_hit ? 1 : 0;
    foreach (recent[i]) recent[i] = '0;
    rec_count = 0;
    rec_hit = 1'b0;
    return v;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_t pick_sym();
    case ($urandom_range(0, 7))
      0: begin
        return 8'h00;
      end
      1, 2: begin
        return 8'h61;
      end
      3, 4: begin
        return 8'h62;
      end
      5: begin
        return 8'hFF;
      end
      default: begin
        return byte_t'($urandom);
      end
    endcase
  endfunction

  function automatic in_beat_t load_beat(int slot, int pos, byte_t val, int len);
    in_beat_t b;
    b = in_beat_t'($urandom);
    b.cmd        = CMD_LOAD;
    b.key_index  = KEY_IDX_W'(slot);
    b.key_pos    = KEY_POS_W'(pos);
    b.key_byte   = val;
    b.key_length = KEY_LEN_W'(len);
    return b;
  endfunction

  function automatic in_beat_t rec_beat(byte_t d, bit last);
    in_beat_t b;
    b = in_beat_t'($urandom);
    b.cmd       = CMD_DATA;
    b.data_byte = d;
    b.last_byte = last;
    return b;
  endfunction

  task automatic drive(in_beat_t b, int typed);
    int gap;
    int v;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= b.cmd;
    in_ch.key_index  <= b.key_index;
    in_ch.key_pos    <= b.key_pos;
    in_ch.key_byte   <= b.key_byte;
    in_ch.key_length <= b.key_length;
    in_ch.data_byte  <= b.data_byte;
    in_ch.last_byte  <= b.last_byte;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    beats_sent++;
    v = filter_step(b);
    if (v >= 0) verdicts_due.push_back((typed >= 0) ? typed[0] : v[0]);
  endtask

  // Active keywords must be fully loaded before a record byte is compared.
  task automatic fill_holes();
    for (int k = 0; k < live_slots(); k++) begin
      for (int p = 0; p < eff_len(k); p++) begin
        if (!key_filled[k][p]) drive(load_beat(k, p, pick_sym(), key_lens[k]), -1);
      end
    end
  endtask

  task automatic send_data(in_beat_t b, int typed);
    fill_holes();
    drive(b, typed);
  endtask

  task automatic set_count(bit [COUNT_W-1:0] v);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    active_keys = v;
  endtask

  task automatic load_keyword();
    int    k;
    int    n;
    int    r;
    byte_t c;
    k = $urandom_range(0, NUM_KEYS - 1);
    r = $urandom_range(0, 9);
    if (r < 6) n = $urandom_range(1, 4);
    else if (r == 6) n = 0;
    else if (r < 9) n = $urandom_range(5, 31);
    else n = $urandom_range(32, 63);
    c = pick_sym();
    for (int p = 0; p < ((n > MAX_KEY_LEN) ? MAX_KEY_LEN : n); p++) begin
      drive(load_beat(k, p, (n >= MAX_KEY_LEN) ? c : pick_sym(), n), -1);
    end
    if (n == 0) drive(load_beat(k, $urandom_range(0, 31), pick_sym(), 0), -1);
    if ($urandom_range(0, 5) == 0) begin
      drive(load_beat($urandom_range(0, 7), $urandom_range(0, 31), byte_t'($urandom),
                      $urandom_range(0, 63)), -1);
    end
  endtask

  task automatic send_record(bit short_rec);
    byte_t rec[$];
    int    n;
    int    k;
    int    at;
    if (short_rec) n = $urandom_range(1, 2);
    else if ($urandom_range(0, 6) == 0) n = $urandom_range(11, 45);
    else n = $urandom_range(1, 10);
    repeat (n) rec.push_back(pick_sym());
    if (live_slots() > 0 && $urandom_range(0, 2) == 0) begin
      k  = $urandom_range(0, live_slots() - 1);
      at = $urandom_range(0, n - 1);
      for (int i = 0; i < eff_len(k); i++) begin
        rec.insert(at + i, key_filled[k][i] ? key_bytes[k][i] : pick_sym());
      end
    end
    foreach (rec[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        drive(load_beat($urandom_range(0, 7), $urandom_range(0, 31), pick_sym(),
                        $urandom_range(0, 8)), -1);
      end
      send_data(rec_beat(rec[i], i == rec.size() - 1), -1);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict with none pending: expected none, actual %0b", $time,
                 out_ch.record_matched);
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.record_matched !== want) begin
          errors++;
          $display("%0t: record_matched mismatch: expected %0b, actual %0b", $time, want,
                   out_ch.record_matched);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : sink_side
    int n;
    bit calm;
    out_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 14) == 0) calm = !calm;
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
      end
      n = pick_gap(calm);
      if (n > 0) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      n = $urandom_range(1, 24);
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  initial begin : source_side
    plan_row_t plan[$];
    bit        hold_done;
    int        r;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOAD;
    in_ch.key_index  = '0;
    in_ch.key_pos    = '0;
    in_ch.key_byte   = '0;
    in_ch.key_length = '0;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;
    foreach (recent[i]) recent[i] = '0;

    // nothing active after reset
    plan.push_back('{1'b0, '0, rec_beat(8'h00, 1'b1), 0});
    plan.push_back('{1'b0, '0, load_beat(0, 0, 8'h61, 2), -1});
    plan.push_back('{1'b0, '0, load_beat(0, 1, 8'h62, 2), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h61, 1'b0), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h62, 1'b1), 0});
    plan.push_back('{1'b1, 4'd1, '0, -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h61, 1'b0), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h62, 1'b1), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h62, 1'b1), 0});
    // zero-valued keyword bytes vs. the cleared window
    plan.push_back('{1'b0, '0, load_beat(1, 0, 8'h00, 2), -1});
    plan.push_back('{1'b0, '0, load_beat(1, 1, 8'h00, 2), -1});
    plan.push_back('{1'b1, 4'd2, '0, -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h00, 1'b1), 0});
    plan.push_back('{1'b0, '0, rec_beat(8'h00, 1'b0), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h00, 1'b1), -1});
    // empty keyword
    plan.push_back('{1'b0, '0, load_beat(2, 31, 8'hFF, 0), -1});
    plan.push_back('{1'b1, 4'd3, '0, -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h37, 1'b1), 1});
    // overlong length, count above slot total
    plan.push_back('{1'b0, '0, load_beat(7, 31, 8'hFF, 63), -1});
    plan.push_back('{1'b1, 4'd15, '0, -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h11, 1'b1), 1});
    // load mid-record: earlier bytes not rechecked
    plan.push_back('{1'b1, 4'd1, '0, -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h41, 1'b0), -1});
    plan.push_back('{1'b0, '0, load_beat(0, 0, 8'h41, 1), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h43, 1'b1), -1});
    plan.push_back('{1'b0, '0, rec_beat(8'h41, 1'b1), 1});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_count(plan[i].cfg);
      else if (plan[i].beat.cmd == CMD_DATA) send_data(plan[i].beat, plan[i].verdict);
      else drive(plan[i].beat, -1);
    end

    while (beats_sent < N_BEATS) begin
      in_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 5);
        if (r == 0) set_count('0);
        else if (r == 1) set_count(COUNT_W'(NUM_KEYS));
        else if (r == 2) set_count('1);
        else set_count(COUNT_W'($urandom_range(1, NUM_KEYS)));
      end
      repeat ($urandom_range(0, 3)) load_keyword();
      repeat ($urandom_range(1, 6)) send_record(1'b0);
      if (!hold_done && beats_sent > N_BEATS / 2) begin
        // long receiver stall while short records keep coming
        hold_done = 1'b1;
        in_calm   = 1'b1;
        hold_req  = 1'b1;
        repeat (40) send_record(1'b1);
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mkrf_pkg.sv
sv/mkrf_in_if.sv
sv/mkrf_out_if.sv
sv/mkrf_key_store.sv
sv/mkrf_matcher.sv
sv/multi_keyword_record_filter.sv
tb/tb.sv
